>>> sv/palette_color_cycler_unit_assert.svh
// Assertion macros for the palette colour cycler.
// No dependencies; included by the modules that check their own logic.
`ifndef PALETTE_COLOR_CYCLER_UNIT_ASSERT_SVH
`define PALETTE_COLOR_CYCLER_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define PCC_ASSERT_IMPL(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
    else $error("pcc assertion failed");
`define PCC_ASSERT_NEXT(lbl, ck, rn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
    else $error("pcc assertion failed");
`else
`define PCC_ASSERT_IMPL(lbl, ck, rn, ante, cons)
`define PCC_ASSERT_NEXT(lbl, ck, rn, ante, cons)
`endif
`endif

>>> sv/pcc_pkg.sv
// Shared constants, codes and interface types of the palette colour cycler.
// No dependencies.
package pcc_pkg;

  localparam int RANGES      = 4;    // one enable bit and one speed register per range
  localparam int MAX_MARKERS = 16;
  localparam int PAL_SIZE    = 256;
  localparam int STEP_UNITS  = 71;

  localparam int OP_W     = 3;
  localparam int RSEL_W   = 2;
  localparam int SLOT_W   = 4;
  localparam int IDX_W    = 8;
  localparam int COLOR_W  = 32;
  localparam int CNT_IN_W = 5;
  localparam int SPD_W    = 7;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 5;
  localparam int REGI_W   = PADDR_W - 2;

  localparam int RW       = (RANGES > 1) ? $clog2(RANGES) : 1;
  localparam int PAL_AW   = (PAL_SIZE > 1) ? $clog2(PAL_SIZE) : 1;
  localparam int MK_DEPTH = RANGES * MAX_MARKERS;
  localparam int MK_AW    = (MK_DEPTH > 1) ? $clog2(MK_DEPTH) : 1;
  localparam int CNT_W    = $clog2(MAX_MARKERS + 1);
  localparam int STEP_W   = (MAX_MARKERS > 1) ? $clog2(MAX_MARKERS) : 1;
  localparam int ACC_W    = $clog2(STEP_UNITS);
  localparam int SUM_W    = ACC_W + 1;

  typedef enum logic [OP_W-1:0] {
    OP_TICK   = 3'd0,
    OP_PAL_WR = 3'd1,
    OP_PAL_RD = 3'd2,
    OP_MK_WR  = 3'd3,
    OP_CNT_WR = 3'd4
  } pcc_op_t;

  typedef enum logic [REGI_W-1:0] {
    REG_MASTER = 3'd0,
    REG_MASK   = 3'd1,
    REG_SPEED0 = 3'd2,
    REG_SPEED1 = 3'd3,
    REG_SPEED2 = 3'd4,
    REG_SPEED3 = 3'd5
  } pcc_reg_t;

  typedef enum logic [1:0] {
    EMIT_ZERO,
    EMIT_COLOR,
    EMIT_MASK
  } pcc_emit_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TICK,
    ST_PAL_SAVED,
    ST_SAVE,
    ST_STEP_PAL,
    ST_STEP_WR,
    ST_FINAL,
    ST_RD_OUT
  } pcc_state_t;

  typedef struct packed {
    logic                        master_en;
    logic [RANGES-1:0]           range_en;
    logic [RANGES-1:0][SPD_W-1:0] speed;
  } pcc_cfg_t;

  typedef struct packed {
    logic      pal_wr_in;
    logic      pal_rd_in;
    logic      mk_wr;
    logic      cnt_wr;
    logic      rng_clr;
    logic      rng_inc;
    logic      rot_clr;
    logic      acc_upd;
    logic      mask_set;
    logic      mk_rd_last;
    logic      step_load;
    logic      step_dec;
    logic      pal_rd_mk;
    logic      dst_cap;
    logic      src_cap;
    logic      saved_cap;
    logic      pal_wr_step;
    logic      pal_wr_saved;
    logic      emit;
    pcc_emit_t emit_sel;
  } pcc_cmd_t;

  typedef struct packed {
    logic idx_ok;
    logic active;
    logic wrap;
    logic cnt_ge2;
    logic rng_last;
    logic step_zero;
  } pcc_stat_t;

endpackage

>>> sv/palette_color_cycler_unit.sv
// Top level of the palette colour cycler: registers, controller, datapath.
// Depends on pcc_pkg, pcc_regs, pcc_ctrl and pcc_datapath.
//
//   channel  ports                       handshake
//   request  start, busy, in_*           taken when start high and busy low
//   result   out_valid, out_*            one-cycle strobe, no back-pressure
//   config   psel, penable, pwrite, ...  APB write on access phase, pready tied high
//
// Palette write, marker write, count write and unknown requests are handled in
// the idle state; busy stays low. A palette read goes through ST_RD_OUT.
// A tick visits each range in ST_TICK and, for each range that rotates markers,
// walks them through ST_STEP_PAL and ST_STEP_WR, one move at a time over the single
// palette port that every moved colour passes through twice.
// Synchronous reset clears config registers, controller state, counts and accumulators; the palette and
// marker memories hold no reset value. The result strobe cannot be stalled.
module palette_color_cycler_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [pcc_pkg::OP_W-1:0]     in_op,
  input  logic [pcc_pkg::RSEL_W-1:0]   in_range_sel,
  input  logic [pcc_pkg::SLOT_W-1:0]   in_slot,
  input  logic [pcc_pkg::IDX_W-1:0]    in_pal_index,
  input  logic [pcc_pkg::COLOR_W-1:0]  in_color_in,
  input  logic [pcc_pkg::CNT_IN_W-1:0] in_marker_count,
  output logic                         out_valid,
  output logic [pcc_pkg::COLOR_W-1:0]  out_color_out,
  output logic [pcc_pkg::RANGES-1:0]   out_rotated_mask,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pcc_pkg::PADDR_W-1:0]  paddr,
  input  logic [pcc_pkg::DATA_W-1:0]   pwdata,
  output logic [pcc_pkg::DATA_W-1:0]   prdata,
  output logic                         pready
);
  import pcc_pkg::*;

  pcc_cfg_t          cfg;
  pcc_cmd_t          cmd;
  pcc_stat_t         st;
  logic [RANGES-1:0] acc_clr;

  pcc_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg),
    .acc_clr (acc_clr)
  );

  pcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .op        (in_op),
    .tick_en   (cfg.master_en),
    .st        (st),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pcc_datapath u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .cfg              (cfg),
    .acc_clr          (acc_clr),
    .in_range_sel     (in_range_sel),
    .in_slot          (in_slot),
    .in_pal_index     (in_pal_index),
    .in_color_in      (in_color_in),
    .in_marker_count  (in_marker_count),
    .out_color_out    (out_color_out),
    .out_rotated_mask (out_rotated_mask)
  );

endmodule

>>> sv/pcc_regs.sv
// Configuration registers behind the APB-style port, with accumulator clears.
// Depends on pcc_pkg.
module pcc_regs (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [pcc_pkg::PADDR_W-1:0] paddr,
  input  logic [pcc_pkg::DATA_W-1:0]  pwdata,
  output logic [pcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output pcc_pkg::pcc_cfg_t           cfg,
  output logic [pcc_pkg::RANGES-1:0]  acc_clr
);
  import pcc_pkg::*;

  logic                         master_r, master_nxt;
  logic [RANGES-1:0]            mask_r, mask_nxt;
  logic [RANGES-1:0][SPD_W-1:0] speed_r, speed_nxt;
  logic                         wr;
  pcc_reg_t                     sel;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign sel    = pcc_reg_t'(paddr[PADDR_W-1:2]);

  always_comb begin
    master_nxt = master_r;
    mask_nxt   = mask_r;
    speed_nxt  = speed_r;
    acc_clr    = '0;
    if (wr) begin
      case (sel)
        REG_MASTER: begin
          master_nxt = pwdata[0];
          acc_clr    = '1;
        end
        REG_MASK: begin
          mask_nxt = pwdata[RANGES-1:0];
          acc_clr  = pwdata[RANGES-1:0] ^ mask_r;
        end
        REG_SPEED0: speed_nxt[0] = pwdata[SPD_W-1:0];
        REG_SPEED1: speed_nxt[1] = pwdata[SPD_W-1:0];
        REG_SPEED2: speed_nxt[2] = pwdata[SPD_W-1:0];
        REG_SPEED3: speed_nxt[3] = pwdata[SPD_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (sel)
      REG_MASTER: prdata = DATA_W'(master_r);
      REG_MASK:   prdata = DATA_W'(mask_r);
      REG_SPEED0: prdata = DATA_W'(speed_r[0]);
      REG_SPEED1: prdata = DATA_W'(speed_r[1]);
      REG_SPEED2: prdata = DATA_W'(speed_r[2]);
      REG_SPEED3: prdata = DATA_W'(speed_r[3]);
      default:    prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      master_r <= 1'b0;
      mask_r   <= '0;
      speed_r  <= '0;
    end else begin
      master_r <= master_nxt;
      mask_r   <= mask_nxt;
      speed_r  <= speed_nxt;
    end
  end

  assign cfg.master_en = master_r;
  assign cfg.range_en  = mask_r;
  assign cfg.speed     = speed_r;

endmodule

>>> sv/pcc_datapath.sv
// Datapath: palette and marker memories, counts, rate accumulators, walk
// counters and result registers. Depends on pcc_pkg and the assertion header.
`include "palette_color_cycler_unit_assert.svh"
module pcc_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pcc_pkg::pcc_cmd_t            cmd,
  output pcc_pkg::pcc_stat_t           st,
  input  pcc_pkg::pcc_cfg_t            cfg,
  input  logic [pcc_pkg::RANGES-1:0]   acc_clr,
  input  logic [pcc_pkg::RSEL_W-1:0]   in_range_sel,
  input  logic [pcc_pkg::SLOT_W-1:0]   in_slot,
  input  logic [pcc_pkg::IDX_W-1:0]    in_pal_index,
  input  logic [pcc_pkg::COLOR_W-1:0]  in_color_in,
  input  logic [pcc_pkg::CNT_IN_W-1:0] in_marker_count,
  output logic [pcc_pkg::COLOR_W-1:0]  out_color_out,
  output logic [pcc_pkg::RANGES-1:0]   out_rotated_mask
);
  import pcc_pkg::*;

  logic [COLOR_W-1:0] pal_mem [PAL_SIZE];
  logic [PAL_AW-1:0]  mk_mem  [MK_DEPTH];

  logic [COLOR_W-1:0] pal_rdata_r;
  logic [PAL_AW-1:0]  mk_rdata_r;
  logic [PAL_AW-1:0]  pal_addr;
  logic [COLOR_W-1:0] pal_wdata;
  logic               pal_we;
  logic [MK_AW-1:0]   mk_raddr, mk_waddr, mk_base;
  logic               mk_we;

  logic [RW-1:0]                rng_r, rng_nxt;
  logic [STEP_W-1:0]            step_r, step_nxt;
  logic [PAL_AW-1:0]            dst_r, dst_nxt, src_r, src_nxt;
  logic [COLOR_W-1:0]           saved_r, saved_nxt;
  logic [RANGES-1:0]            rot_mask_r, rot_mask_nxt;
  logic [RANGES-1:0][CNT_W-1:0] counts_r, counts_nxt;
  logic [RANGES-1:0][ACC_W-1:0] acc_r, acc_nxt;
  logic [COLOR_W-1:0]           out_color_r, out_color_nxt;
  logic [RANGES-1:0]            out_mask_r, out_mask_nxt;

  logic [CNT_W-1:0] cur_cnt;
  logic [SPD_W-1:0] spd_raw, spd;
  logic [SUM_W-1:0] sum;
  logic             idx_ok, mk_ok, rsel_ok, acc_ovf;
  logic [CNT_W-1:0] cnt_sat;

  assign idx_ok  = 32'(in_pal_index) < PAL_SIZE;
  assign rsel_ok = 32'(in_range_sel) < RANGES;
  assign mk_ok   = rsel_ok && (32'(in_slot) < MAX_MARKERS) && idx_ok;
  assign cnt_sat = (32'(in_marker_count) > MAX_MARKERS) ? CNT_W'(MAX_MARKERS)
                                                        : CNT_W'(in_marker_count);

  // Rate step for the range under the walk pointer
  assign cur_cnt = counts_r[rng_r];
  assign spd_raw = cfg.speed[rng_r];
  assign spd     = (32'(spd_raw) > STEP_UNITS) ? SPD_W'(STEP_UNITS) : spd_raw;
  assign sum     = SUM_W'(acc_r[rng_r]) + SUM_W'(spd);

  assign st.idx_ok    = idx_ok;
  assign st.active    = cfg.range_en[rng_r] && (spd_raw != '0);
  assign st.wrap      = sum >= SUM_W'(STEP_UNITS);
  assign st.cnt_ge2   = cur_cnt >= CNT_W'(2);
  assign st.rng_last  = rng_r == RW'(RANGES - 1);
  assign st.step_zero = step_r == '0;

  // Marker memory: one write port for loads, one read port for the walk
  assign mk_base  = MK_AW'(32'(rng_r) * MAX_MARKERS);
  assign mk_raddr = cmd.mk_rd_last ? (mk_base + MK_AW'(cur_cnt) - MK_AW'(1))
                                   : (mk_base + MK_AW'(step_r) - MK_AW'(1));
  assign mk_waddr = MK_AW'(32'(in_range_sel) * MAX_MARKERS + 32'(in_slot));
  assign mk_we    = cmd.mk_wr && mk_ok;

  always_ff @(posedge clk) begin
    if (mk_we) begin
      mk_mem[mk_waddr] <= PAL_AW'(in_pal_index);
    end
    mk_rdata_r <= mk_mem[mk_raddr];
  end

  // Palette: single port, one read or one write a cycle
  always_comb begin
    pal_we    = (cmd.pal_wr_in && idx_ok) || cmd.pal_wr_step || cmd.pal_wr_saved;
    pal_wdata = saved_r;
    pal_addr  = dst_r;
    if (cmd.pal_wr_in || cmd.pal_rd_in) begin
      pal_addr = PAL_AW'(in_pal_index);
    end else if (cmd.pal_rd_mk) begin
      pal_addr = mk_rdata_r;
    end
    if (cmd.pal_wr_in) begin
      pal_wdata = in_color_in;
    end else if (cmd.pal_wr_step) begin
      pal_wdata = pal_rdata_r;
    end
  end

  always_ff @(posedge clk) begin
    if (pal_we) begin
      pal_mem[pal_addr] <= pal_wdata;
    end
    pal_rdata_r <= pal_mem[pal_addr];
  end

  always_comb begin
    rng_nxt      = rng_r;
    step_nxt     = step_r;
    dst_nxt      = dst_r;
    src_nxt      = src_r;
    saved_nxt    = saved_r;
    rot_mask_nxt = rot_mask_r;
    counts_nxt   = counts_r;
    acc_nxt      = acc_r;
    acc_ovf      = 1'b0;
    out_color_nxt = out_color_r;
    out_mask_nxt  = out_mask_r;

    if (cmd.rng_clr) rng_nxt = '0;
    else if (cmd.rng_inc) rng_nxt = rng_r + RW'(1);

    if (cmd.step_load) step_nxt = STEP_W'(cur_cnt - CNT_W'(1));
    else if (cmd.step_dec) step_nxt = step_r - STEP_W'(1);

    if (cmd.dst_cap) dst_nxt = mk_rdata_r;
    else if (cmd.pal_wr_step) dst_nxt = src_r;
    if (cmd.src_cap) src_nxt = mk_rdata_r;
    if (cmd.saved_cap) saved_nxt = pal_rdata_r;

    if (cmd.rot_clr) rot_mask_nxt = '0;
    else if (cmd.mask_set) rot_mask_nxt[rng_r] = 1'b1;

    if (cmd.cnt_wr && rsel_ok) counts_nxt[in_range_sel] = cnt_sat;

    if (cmd.acc_upd) begin
      acc_nxt[rng_r] = st.wrap ? ACC_W'(sum - SUM_W'(STEP_UNITS)) : ACC_W'(sum);
    end
    for (int r = 0; r < RANGES; r++) begin
      if (acc_clr[r]) acc_nxt[r] = '0;
      acc_ovf = acc_ovf | (32'(acc_r[r]) >= STEP_UNITS);
    end

    if (cmd.emit) begin
      out_color_nxt = (cmd.emit_sel == EMIT_COLOR) ? pal_rdata_r : '0;
      out_mask_nxt  = (cmd.emit_sel == EMIT_MASK) ? rot_mask_r : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      counts_r <= '0;
      acc_r    <= '0;
      rng_r    <= '0;
      step_r   <= '0;
    end else begin
      counts_r <= counts_nxt;
      acc_r    <= acc_nxt;
      rng_r    <= rng_nxt;
      step_r   <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dst_r       <= dst_nxt;
    src_r       <= src_nxt;
    saved_r     <= saved_nxt;
    rot_mask_r  <= rot_mask_nxt;
    out_color_r <= out_color_nxt;
    out_mask_r  <= out_mask_nxt;
  end

  assign out_color_out    = out_color_r;
  assign out_rotated_mask = out_mask_r;

  `PCC_ASSERT_IMPL(a_pal_single_port, clk, rst_n, pal_we, !(cmd.pal_rd_in || cmd.pal_rd_mk))
  `PCC_ASSERT_IMPL(a_acc_below_step, clk, rst_n, 1'b1, !acc_ovf)

endmodule

>>> sv/pcc_ctrl.sv
// Controller: request decode and the tick walk over ranges and markers.
// Depends on pcc_pkg and the assertion header.
`include "palette_color_cycler_unit_assert.svh"
module pcc_ctrl (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [pcc_pkg::OP_W-1:0] op,
  input  logic                     tick_en,
  input  pcc_pkg::pcc_stat_t       st,
  output pcc_pkg::pcc_cmd_t        cmd,
  output logic                     busy,
  output logic                     out_valid
);
  import pcc_pkg::*;

  pcc_state_t state_r, state_nxt;
  logic       out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.emit;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          case (pcc_op_t'(op))
            OP_TICK: begin
              if (tick_en) begin
                cmd.rng_clr = 1'b1;
                cmd.rot_clr = 1'b1;
                state_nxt   = ST_TICK;
              end else begin
                cmd.emit = 1'b1;
              end
            end
            OP_PAL_WR: begin
              cmd.pal_wr_in = 1'b1;
              cmd.emit      = 1'b1;
            end
            OP_PAL_RD: begin
              if (st.idx_ok) begin
                cmd.pal_rd_in = 1'b1;
                state_nxt     = ST_RD_OUT;
              end else begin
                cmd.emit = 1'b1;
              end
            end
            OP_MK_WR: begin
              cmd.mk_wr = 1'b1;
              cmd.emit  = 1'b1;
            end
            OP_CNT_WR: begin
              cmd.cnt_wr = 1'b1;
              cmd.emit   = 1'b1;
            end
            default: cmd.emit = 1'b1;
          endcase
        end
      end
      ST_RD_OUT: begin
        cmd.emit     = 1'b1;
        cmd.emit_sel = EMIT_COLOR;
        state_nxt    = ST_IDLE;
      end
      ST_TICK: begin
        cmd.acc_upd = st.active;
        if (st.active && st.wrap && st.cnt_ge2) begin
          // fetch the last marker and start the rotation
          cmd.mask_set   = 1'b1;
          cmd.mk_rd_last = 1'b1;
          cmd.step_load  = 1'b1;
          state_nxt      = ST_PAL_SAVED;
        end else if (st.rng_last) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_MASK;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.rng_inc = 1'b1;
        end
      end
      ST_PAL_SAVED: begin
        cmd.pal_rd_mk = 1'b1;
        cmd.dst_cap   = 1'b1;
        state_nxt     = ST_SAVE;
      end
      ST_SAVE: begin
        cmd.saved_cap = 1'b1;
        cmd.pal_rd_mk = 1'b1;
        cmd.src_cap   = 1'b1;
        cmd.step_dec  = 1'b1;
        state_nxt     = ST_STEP_WR;
      end
      ST_STEP_PAL: begin
        cmd.pal_rd_mk = 1'b1;
        cmd.src_cap   = 1'b1;
        cmd.step_dec  = 1'b1;
        state_nxt     = ST_STEP_WR;
      end
      ST_STEP_WR: begin
        cmd.pal_wr_step = 1'b1;
        state_nxt       = st.step_zero ? ST_FINAL : ST_STEP_PAL;
      end
      ST_FINAL: begin
        // close the ring with the colour saved from the last marker
        cmd.pal_wr_saved = 1'b1;
        if (st.rng_last) begin
          cmd.emit     = 1'b1;
          cmd.emit_sel = EMIT_MASK;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.rng_inc = 1'b1;
          state_nxt   = ST_TICK;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy      = state_r != ST_IDLE;
  assign out_valid = out_valid_r;

  `PCC_ASSERT_IMPL(a_walk_needs_enable, clk, rst_n, (busy && state_r != ST_RD_OUT), tick_en)
  `PCC_ASSERT_IMPL(a_rotate_two_markers, clk, rst_n, state_r == ST_PAL_SAVED, st.cnt_ge2)
  `PCC_ASSERT_NEXT(a_tick_walks, clk, rst_n, (start && !busy && op == OP_TICK && tick_en), busy)

endmodule
